FILE: hdl/qstm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qstm_pkg
// shared types, constants and the saturation helper for the pose-to-matrix
// pipeline
// ----------------------------------------------------------------------------
package qstm_pkg;

	// widths of the fixed-point data path
	localparam int QUAT_W  = 16;                 // Q1.14 quaternion component
	localparam int SCALE_W = 16;                 // Q8.8 scale
	localparam int POS_W   = 32;                 // Q16.16 position and outputs
	localparam int TAG_W   = 16;
	localparam int ROW_W   = 2;
	localparam int QPROD_W = 2 * QUAT_W;         // one quaternion product
	localparam int ROT_W   = QPROD_W + 3;        // rotation term, Q.28 with headroom
	localparam int PPROD_W = POS_W + SCALE_W;    // position times scale
	localparam int WIDE_W  = ROT_W + SCALE_W;    // rotation term times scale

	// rotation entries per matrix row
	localparam int NUM_ENT = 3;

	// row code of the fixed bottom row
	localparam logic [ROW_W-1:0] ROW_FIXED = 2'd3;
	localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;

	// one in Q.28 and in Q16.16
	localparam logic signed [ROT_W-1:0] ONE_Q28 = 35'sd268435456;
	localparam logic signed [POS_W-1:0] ONE_Q16 = 32'sd65536;

	// rounding offsets: half an lsb before the floor shift
	localparam logic signed [WIDE_W-1:0]  RND_ROT = 51'sd524288;
	localparam int                        SH_ROT  = 20;
	localparam logic signed [PPROD_W-1:0] RND_POS = 48'sd128;
	localparam int                        SH_POS  = 8;

	localparam logic signed [WIDE_W-1:0] SAT_MAX = 51'sd2147483647;
	localparam logic signed [WIDE_W-1:0] SAT_MIN = -51'sd2147483648;

	// operands of one rotation entry: base + sign * 2 * (a*b +/- c*d)
	typedef struct packed {
		logic signed [QUAT_W-1:0] a;
		logic signed [QUAT_W-1:0] b;
		logic signed [QUAT_W-1:0] c;
		logic signed [QUAT_W-1:0] d;
		logic                     diag;   // entry is one minus the doubled sum
		logic                     sub;    // second product is subtracted
	} term_op_t;

	// tag and row number that travel with each row word
	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [ROW_W-1:0] row;
	} row_ctl_t;

	// clamp a wide signed value to the 32-bit signed range
	function automatic logic signed [POS_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [POS_W-1:0] r;
		if (v > SAT_MAX)
			r = SAT_MAX[POS_W-1:0];
		else if (v < SAT_MIN)
			r = SAT_MIN[POS_W-1:0];
		else
			r = v[POS_W-1:0];
		return r;
	endfunction

endpackage

FILE: hdl/quat_scale_translate_to_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quat_scale_translate_to_matrix
// builds the transposed affine matrix of one object pose (rotation quaternion,
// position, per-axis scale) and streams it out as four row words
// ----------------------------------------------------------------------------
//
// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+----------------------------
// pose in  | in        | start high, busy low       | quat_x..w, pos_x..z,
//          |           |                            | scale_x..z, object_id
// row out  | out       | result_strobe, one cycle   | object_tag, row_index,
//          |           |                            | col0..col3, last_row
//
// one pose word is taken per four row words, set by the single row output port:
// a pose is issued into the pipeline one row per cycle, rows 0 to 3
// the next pose is taken during the cycle in which row 3 of the current one
// issues, so rows leave back to back with no gap
// row 0 of a pose passes the operand, product, term, scaled and output registers
// arst_n clears the issue control and the valid bits of all stages
// the receiver cannot stall, so the pipeline never holds; busy only paces input
//
module quat_scale_translate_to_matrix (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic signed [qstm_pkg::QUAT_W-1:0]     quat_x,
	input  logic signed [qstm_pkg::QUAT_W-1:0]     quat_y,
	input  logic signed [qstm_pkg::QUAT_W-1:0]     quat_z,
	input  logic signed [qstm_pkg::QUAT_W-1:0]     quat_w,
	input  logic signed [qstm_pkg::POS_W-1:0]      pos_x,
	input  logic signed [qstm_pkg::POS_W-1:0]      pos_y,
	input  logic signed [qstm_pkg::POS_W-1:0]      pos_z,
	input  logic signed [qstm_pkg::SCALE_W-1:0]    scale_x,
	input  logic signed [qstm_pkg::SCALE_W-1:0]    scale_y,
	input  logic signed [qstm_pkg::SCALE_W-1:0]    scale_z,
	input  logic        [qstm_pkg::TAG_W-1:0]      object_id,
	output logic                                   result_strobe,
	output logic        [qstm_pkg::TAG_W-1:0]      object_tag,
	output logic        [qstm_pkg::ROW_W-1:0]      row_index,
	output logic signed [qstm_pkg::POS_W-1:0]      col0,
	output logic signed [qstm_pkg::POS_W-1:0]      col1,
	output logic signed [qstm_pkg::POS_W-1:0]      col2,
	output logic signed [qstm_pkg::POS_W-1:0]      col3,
	output logic                                   last_row
);

	// ------------------------------------------------------------------
	// issue stage: pose hold registers and row counter
	// ------------------------------------------------------------------
	logic                                  accept;
	logic                                  act_q;      // a pose is issuing rows
	logic [qstm_pkg::ROW_W-1:0]            row_q;      // row issued this cycle
	logic signed [qstm_pkg::QUAT_W-1:0]    qx_q, qy_q, qz_q, qw_q;
	logic signed [qstm_pkg::POS_W-1:0]     px_q, py_q, pz_q;
	logic signed [qstm_pkg::SCALE_W-1:0]   sx_q, sy_q, sz_q;
	logic [qstm_pkg::TAG_W-1:0]            tag_q;

	// free during the idle state and while the last row issues
	assign busy   = act_q && (row_q != qstm_pkg::ROW_FIXED);
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			row_q <= qstm_pkg::ROW_FIRST;
		end else if (accept) begin
			act_q <= 1'b1;
			row_q <= qstm_pkg::ROW_FIRST;
		end else if (act_q) begin
			if (row_q == qstm_pkg::ROW_FIXED)
				act_q <= 1'b0;
			else
				row_q <= row_q + 2'd1;
		end
	end

	// pose word held while its rows issue
	always_ff @(posedge clk) begin
		if (accept) begin
			qx_q  <= quat_x;
			qy_q  <= quat_y;
			qz_q  <= quat_z;
			qw_q  <= quat_w;
			px_q  <= pos_x;
			py_q  <= pos_y;
			pz_q  <= pos_z;
			sx_q  <= scale_x;
			sy_q  <= scale_y;
			sz_q  <= scale_z;
			tag_q <= object_id;
		end
	end

	// ------------------------------------------------------------------
	// operand select: column k of the rotation matrix for row k
	// ------------------------------------------------------------------
	qstm_pkg::term_op_t                    op_c [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::SCALE_W-1:0]   scale_c;
	logic signed [qstm_pkg::POS_W-1:0]     pos_c;

	always_comb begin
		op_c[0] = '{a: qy_q, b: qy_q, c: qz_q, d: qz_q, diag: 1'b1, sub: 1'b0};
		op_c[1] = '{a: qx_q, b: qy_q, c: qw_q, d: qz_q, diag: 1'b0, sub: 1'b1};
		op_c[2] = '{a: qx_q, b: qz_q, c: qw_q, d: qy_q, diag: 1'b0, sub: 1'b0};
		scale_c = sx_q;
		pos_c   = px_q;
		case (row_q)
			2'd0: begin
				// r00 = 1-2(yy+zz), r10 = 2(xy-wz), r20 = 2(xz+wy): defaults
			end
			2'd1: begin
				op_c[0] = '{a: qx_q, b: qy_q, c: qw_q, d: qz_q, diag: 1'b0, sub: 1'b0};
				op_c[1] = '{a: qx_q, b: qx_q, c: qz_q, d: qz_q, diag: 1'b1, sub: 1'b0};
				op_c[2] = '{a: qy_q, b: qz_q, c: qw_q, d: qx_q, diag: 1'b0, sub: 1'b1};
				scale_c = sy_q;
				pos_c   = py_q;
			end
			2'd2: begin
				op_c[0] = '{a: qx_q, b: qz_q, c: qw_q, d: qy_q, diag: 1'b0, sub: 1'b1};
				op_c[1] = '{a: qy_q, b: qz_q, c: qw_q, d: qx_q, diag: 1'b0, sub: 1'b0};
				op_c[2] = '{a: qx_q, b: qx_q, c: qy_q, d: qy_q, diag: 1'b1, sub: 1'b0};
				scale_c = sz_q;
				pos_c   = pz_q;
			end
			default: begin
				// fixed bottom row: operands unused, replaced at the output
			end
		endcase
	end

	// ------------------------------------------------------------------
	// stage 1: registered operands
	// ------------------------------------------------------------------
	logic                                  v_s1;
	qstm_pkg::term_op_t                    op_s1 [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::SCALE_W-1:0]   scale_s1;
	logic signed [qstm_pkg::POS_W-1:0]     pos_s1;
	qstm_pkg::row_ctl_t                    ctl_s1;

	// ------------------------------------------------------------------
	// stage 2: quaternion products and position times scale
	// ------------------------------------------------------------------
	logic                                  v_s2;
	logic signed [qstm_pkg::QPROD_W-1:0]   pab_s2 [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::QPROD_W-1:0]   pcd_s2 [qstm_pkg::NUM_ENT];
	logic [qstm_pkg::NUM_ENT-1:0]          diag_s2, sub_s2;
	logic signed [qstm_pkg::SCALE_W-1:0]   scale_s2;
	logic signed [qstm_pkg::PPROD_W-1:0]   pp_s2;
	qstm_pkg::row_ctl_t                    ctl_s2;

	// ------------------------------------------------------------------
	// stage 3: rotation terms in Q.28, translation rounded and clamped
	// ------------------------------------------------------------------
	logic                                  v_s3;
	logic signed [qstm_pkg::ROT_W-1:0]     rot_s3 [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::SCALE_W-1:0]   scale_s3;
	logic signed [qstm_pkg::POS_W-1:0]     pt_s3;
	qstm_pkg::row_ctl_t                    ctl_s3;

	// ------------------------------------------------------------------
	// stage 4: rotation term times scale
	// ------------------------------------------------------------------
	logic                                  v_s4;
	logic signed [qstm_pkg::WIDE_W-1:0]    rs_s4 [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::POS_W-1:0]     pt_s4;
	qstm_pkg::row_ctl_t                    ctl_s4;

	// ------------------------------------------------------------------
	// stage 5: output word registers
	// ------------------------------------------------------------------
	logic                                  v_s5;
	logic signed [qstm_pkg::POS_W-1:0]     col_s5 [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::POS_W-1:0]     col3_s5;
	logic                                  last_s5;
	qstm_pkg::row_ctl_t                    ctl_s5;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= act_q;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// combinational pieces between stages
	logic signed [qstm_pkg::QPROD_W:0]     sum_c   [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::ROT_W-1:0]     twice_c [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::ROT_W-1:0]     rot_c   [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::PPROD_W-1:0]   prnd_c, psh_c;
	logic signed [qstm_pkg::WIDE_W-1:0]    rrnd_c  [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::WIDE_W-1:0]    rsh_c   [qstm_pkg::NUM_ENT];
	logic signed [qstm_pkg::POS_W-1:0]     rsat_c  [qstm_pkg::NUM_ENT];

	always_comb begin
		for (int i = 0; i < qstm_pkg::NUM_ENT; i++) begin
			// a*b +/- c*d, then doubled, then one minus it on the diagonal
			if (sub_s2[i])
				sum_c[i] = {pab_s2[i][qstm_pkg::QPROD_W-1], pab_s2[i]}
					- {pcd_s2[i][qstm_pkg::QPROD_W-1], pcd_s2[i]};
			else
				sum_c[i] = {pab_s2[i][qstm_pkg::QPROD_W-1], pab_s2[i]}
					+ {pcd_s2[i][qstm_pkg::QPROD_W-1], pcd_s2[i]};
			twice_c[i] = {sum_c[i][qstm_pkg::QPROD_W], sum_c[i], 1'b0};
			rot_c[i]   = diag_s2[i] ? (qstm_pkg::ONE_Q28 - twice_c[i]) : twice_c[i];

			// round half up to Q16.16 and clamp
			rrnd_c[i] = rs_s4[i] + qstm_pkg::RND_ROT;
			rsh_c[i]  = rrnd_c[i] >>> qstm_pkg::SH_ROT;
			rsat_c[i] = qstm_pkg::sat32(rsh_c[i]);
		end
		prnd_c = pp_s2 + qstm_pkg::RND_POS;
		psh_c  = prnd_c >>> qstm_pkg::SH_POS;
	end

	// data path registers
	always_ff @(posedge clk) begin
		// stage 1
		for (int i = 0; i < qstm_pkg::NUM_ENT; i++)
			op_s1[i] <= op_c[i];
		scale_s1   <= scale_c;
		pos_s1     <= pos_c;
		ctl_s1.tag <= tag_q;
		ctl_s1.row <= row_q;

		// stage 2
		for (int i = 0; i < qstm_pkg::NUM_ENT; i++) begin
			pab_s2[i]  <= op_s1[i].a * op_s1[i].b;
			pcd_s2[i]  <= op_s1[i].c * op_s1[i].d;
			diag_s2[i] <= op_s1[i].diag;
			sub_s2[i]  <= op_s1[i].sub;
		end
		pp_s2    <= pos_s1 * scale_s1;
		scale_s2 <= scale_s1;
		ctl_s2   <= ctl_s1;

		// stage 3
		for (int i = 0; i < qstm_pkg::NUM_ENT; i++)
			rot_s3[i] <= rot_c[i];
		pt_s3    <= qstm_pkg::sat32({{(qstm_pkg::WIDE_W - qstm_pkg::PPROD_W)
			{psh_c[qstm_pkg::PPROD_W-1]}}, psh_c});
		scale_s3 <= scale_s2;
		ctl_s3   <= ctl_s2;

		// stage 4
		for (int i = 0; i < qstm_pkg::NUM_ENT; i++)
			rs_s4[i] <= rot_s3[i] * scale_s3;
		pt_s4  <= pt_s3;
		ctl_s4 <= ctl_s3;

		// stage 5: bottom row is the constant 0, 0, 0, 1
		ctl_s5 <= ctl_s4;
		if (ctl_s4.row == qstm_pkg::ROW_FIXED) begin
			for (int i = 0; i < qstm_pkg::NUM_ENT; i++)
				col_s5[i] <= '0;
			col3_s5 <= qstm_pkg::ONE_Q16;
			last_s5 <= 1'b1;
		end else begin
			for (int i = 0; i < qstm_pkg::NUM_ENT; i++)
				col_s5[i] <= rsat_c[i];
			col3_s5 <= pt_s4;
			last_s5 <= 1'b0;
		end
	end

	// output word
	assign result_strobe = v_s5;
	assign object_tag    = ctl_s5.tag;
	assign row_index     = ctl_s5.row;
	assign col0          = col_s5[0];
	assign col1          = col_s5[1];
	assign col2          = col_s5[2];
	assign col3          = col3_s5;
	assign last_row      = last_s5;

`ifndef NO_ASSERTIONS
	// an accepted pose blocks input while its first rows issue
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after a pose was accepted");

	// rows of one pose leave on consecutive cycles in order
	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_row) |=>
			(result_strobe && (row_index == $past(row_index) + 2'd1)))
		else $error("row words of a pose are not back to back in order");

	// every row after the first carries the tag of the row before it
	a_tag_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && (row_index != qstm_pkg::ROW_FIRST)) |->
			($past(result_strobe) && (object_tag == $past(object_tag))))
		else $error("object tag changed inside one matrix");

	// the last-row flag marks exactly the fixed bottom row
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> (last_row == (row_index == qstm_pkg::ROW_FIXED)))
		else $error("last_row does not match the row number");
`endif

endmodule

FILE: tb/tb_quat_scale_translate_to_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quat_scale_translate_to_matrix
// self-checking bench for the pose-to-matrix builder: a directed table of
// poses, then random poses sent in bursts, with every row word compared against
// hand-written values or against an in-bench fixed-point predictor
// ----------------------------------------------------------------------------
module tb_quat_scale_translate_to_matrix;

	// one pose word as it goes into the block
	typedef struct packed {
		logic signed [qstm_pkg::QUAT_W-1:0]  qx;
		logic signed [qstm_pkg::QUAT_W-1:0]  qy;
		logic signed [qstm_pkg::QUAT_W-1:0]  qz;
		logic signed [qstm_pkg::QUAT_W-1:0]  qw;
		logic signed [qstm_pkg::POS_W-1:0]   px;
		logic signed [qstm_pkg::POS_W-1:0]   py;
		logic signed [qstm_pkg::POS_W-1:0]   pz;
		logic signed [qstm_pkg::SCALE_W-1:0] sx;
		logic signed [qstm_pkg::SCALE_W-1:0] sy;
		logic signed [qstm_pkg::SCALE_W-1:0] sz;
		logic [qstm_pkg::TAG_W-1:0]          id;
	} pose_t;

	// one row word as it leaves the block
	typedef struct packed {
		logic [qstm_pkg::TAG_W-1:0]        tag;
		logic [qstm_pkg::ROW_W-1:0]        row;
		logic signed [qstm_pkg::POS_W-1:0] c0;
		logic signed [qstm_pkg::POS_W-1:0] c1;
		logic signed [qstm_pkg::POS_W-1:0] c2;
		logic signed [qstm_pkg::POS_W-1:0] c3;
		logic                              last;
	} row_word_t;

	// directed table entry; typed rows carry a diagonal rotation part and
	// the translation column written out by hand
	typedef struct packed {
		pose_t                           pose;
		logic                            typed;
		logic [2:0][qstm_pkg::POS_W-1:0] dg;
		logic [2:0][qstm_pkg::POS_W-1:0] tr;
	} pose_case_t;

	logic                                clk;
	logic                                arst_n;
	logic                                start;
	logic                                busy;
	logic signed [qstm_pkg::QUAT_W-1:0]  quat_x, quat_y, quat_z, quat_w;
	logic signed [qstm_pkg::POS_W-1:0]   pos_x, pos_y, pos_z;
	logic signed [qstm_pkg::SCALE_W-1:0] scale_x, scale_y, scale_z;
	logic [qstm_pkg::TAG_W-1:0]          object_id;
	logic                                result_strobe;
	logic [qstm_pkg::TAG_W-1:0]          object_tag;
	logic [qstm_pkg::ROW_W-1:0]          row_index;
	logic signed [qstm_pkg::POS_W-1:0]   col0, col1, col2, col3;
	logic                                last_row;

	// rows still owed by the block, oldest first
	row_word_t  rows_owed[$];
	pose_case_t pose_table[$];

	int errors;
	int rows_checked;
	int poses_sent;
	int directed_count;
	int burst_left;

	quat_scale_translate_to_matrix dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.quat_x        (quat_x),
		.quat_y        (quat_y),
		.quat_z        (quat_z),
		.quat_w        (quat_w),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.scale_x       (scale_x),
		.scale_y       (scale_y),
		.scale_z       (scale_z),
		.object_id     (object_id),
		.result_strobe (result_strobe),
		.object_tag    (object_tag),
		.row_index     (row_index),
		.col0          (col0),
		.col1          (col1),
		.col2          (col2),
		.col3          (col3),
		.last_row      (last_row)
	);

	// 50 MHz clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop in case the handshake or the drain hangs
	initial begin
		#5_000_000;
		$display("quat_scale_translate_to_matrix regression: fail");
		$finish;
	end

	// round half up by a floor shift, then clamp to the signed 32-bit range
	function automatic logic signed [qstm_pkg::POS_W-1:0] round_clamp(longint v, int sh);
		longint t;
		t = (v + (longint'(1) << (sh - 1))) >>> sh;
		if (t > longint'(32'sh7fffffff))
			t = longint'(32'sh7fffffff);
		else if (t < -longint'(64'sd2147483648))
			t = -longint'(64'sd2147483648);
		return t[qstm_pkg::POS_W-1:0];
	endfunction

	// queue the four row words that one accepted pose will produce
	function automatic void queue_matrix_rows(pose_case_t pc);
		longint    x, y, z, w;
		longint    s[3];
		longint    p[3];
		longint    r[3][3];
		row_word_t wd;
		int        k;
		x = pc.pose.qx;
		y = pc.pose.qy;
		z = pc.pose.qz;
		w = pc.pose.qw;
		s[0] = pc.pose.sx;
		s[1] = pc.pose.sy;
		s[2] = pc.pose.sz;
		p[0] = pc.pose.px;
		p[1] = pc.pose.py;
		p[2] = pc.pose.pz;
		// rotation terms, exact in q.28, quaternion taken as it is
		r[0][0] = (longint'(1) << 28) - 2 * (y * y + z * z);
		r[0][1] = 2 * (x * y + w * z);
		r[0][2] = 2 * (x * z - w * y);
		r[1][0] = 2 * (x * y - w * z);
		r[1][1] = (longint'(1) << 28) - 2 * (x * x + z * z);
		r[1][2] = 2 * (y * z + w * x);
		r[2][0] = 2 * (x * z + w * y);
		r[2][1] = 2 * (y * z - w * x);
		r[2][2] = (longint'(1) << 28) - 2 * (x * x + y * y);
		for (k = 0; k < qstm_pkg::NUM_ENT; k++) begin
			wd.tag  = pc.pose.id;
			wd.row  = qstm_pkg::ROW_W'(k);
			wd.last = 1'b0;
			if (pc.typed) begin
				wd.c0 = (k == 0) ? pc.dg[k] : '0;
				wd.c1 = (k == 1) ? pc.dg[k] : '0;
				wd.c2 = (k == 2) ? pc.dg[k] : '0;
				wd.c3 = pc.tr[k];
			end else begin
				// row k is column k of r, times the scale of axis k
				wd.c0 = round_clamp(r[0][k] * s[k], qstm_pkg::SH_ROT);
				wd.c1 = round_clamp(r[1][k] * s[k], qstm_pkg::SH_ROT);
				wd.c2 = round_clamp(r[2][k] * s[k], qstm_pkg::SH_ROT);
				wd.c3 = round_clamp(p[k] * s[k], qstm_pkg::SH_POS);
			end
			rows_owed = {rows_owed, wd};
		end
		// bottom row of the affine matrix never changes
		wd.tag  = pc.pose.id;
		wd.row  = qstm_pkg::ROW_FIXED;
		wd.c0   = '0;
		wd.c1   = '0;
		wd.c2   = '0;
		wd.c3   = qstm_pkg::ONE_Q16;
		wd.last = 1'b1;
		rows_owed = {rows_owed, wd};
	endfunction

	function automatic pose_t mk_pose(int qx, int qy, int qz, int qw,
	                                  logic [31:0] px, logic [31:0] py, logic [31:0] pz,
	                                  int sx, int sy, int sz, int id);
		pose_t p;
		p.qx = qx[qstm_pkg::QUAT_W-1:0];
		p.qy = qy[qstm_pkg::QUAT_W-1:0];
		p.qz = qz[qstm_pkg::QUAT_W-1:0];
		p.qw = qw[qstm_pkg::QUAT_W-1:0];
		p.px = px;
		p.py = py;
		p.pz = pz;
		p.sx = sx[qstm_pkg::SCALE_W-1:0];
		p.sy = sy[qstm_pkg::SCALE_W-1:0];
		p.sz = sz[qstm_pkg::SCALE_W-1:0];
		p.id = id[qstm_pkg::TAG_W-1:0];
		return p;
	endfunction

	// table row checked against the predictor
	function automatic void table_model(pose_t p);
		pose_case_t pc;
		pc.pose  = p;
		pc.typed = 1'b0;
		pc.dg    = '0;
		pc.tr    = '0;
		pose_table = {pose_table, pc};
	endfunction

	// table row with the result written out: diagonal entries and translation
	function automatic void table_typed(pose_t p,
	                                    logic [31:0] d0, logic [31:0] d1, logic [31:0] d2,
	                                    logic [31:0] t0, logic [31:0] t1, logic [31:0] t2);
		pose_case_t pc;
		pc.pose  = p;
		pc.typed = 1'b1;
		pc.dg[0] = d0;
		pc.dg[1] = d1;
		pc.dg[2] = d2;
		pc.tr[0] = t0;
		pc.tr[1] = t1;
		pc.tr[2] = t2;
		pose_table = {pose_table, pc};
	endfunction

	function automatic int rand_quat();
		int v;
		case ($urandom_range(0, 7))
			0: v = 16384;
			1: v = -16384;
			2: v = 0;
			default: v = int'($urandom_range(0, 32768)) - 16384;
		endcase
		return v;
	endfunction

	function automatic logic [31:0] rand_pos();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0: v = 32'h7fff_ffff;
			1: v = 32'h8000_0000;
			2, 3: v = 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic int rand_scale();
		int v;
		case ($urandom_range(0, 7))
			0: v = 32767;
			1: v = -32768;
			2, 3: v = 256 + int'($urandom_range(0, 64)) - 32;
			default: v = int'($urandom_range(0, 65535));
		endcase
		return v;
	endfunction

	// offer one pose word, sometimes pausing first when a burst has run out, and
	// return once busy is low again, so that the next word can be taken
	task automatic send_pose(pose_t p);
		int gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
			burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		start     <= 1'b1;
		quat_x    <= p.qx;
		quat_y    <= p.qy;
		quat_z    <= p.qz;
		quat_w    <= p.qw;
		pos_x     <= p.px;
		pos_y     <= p.py;
		pos_z     <= p.pz;
		scale_x   <= p.sx;
		scale_y   <= p.sy;
		scale_z   <= p.sz;
		object_id <= p.id;
		@(posedge clk);
		while (busy) @(posedge clk);
		poses_sent++;
	endtask

	// row word checker: the block cannot be held off, so every strobe is a
	// word that must match the oldest one owed
	always @(posedge clk) begin
		row_word_t e;
		if (arst_n && result_strobe === 1'b1) begin
			if (rows_owed.size() == 0) begin
				$error("row word with nothing owed: tag %0h row %0d", object_tag, row_index);
				errors++;
			end else begin
				e = rows_owed.pop_front();
				rows_checked++;
				if (object_tag !== e.tag) begin
					$error("object_tag: expected %0h, got %0h", e.tag, object_tag);
					errors++;
				end
				if (row_index !== e.row) begin
					$error("row_index: expected %0d, got %0d", e.row, row_index);
					errors++;
				end
				if (col0 !== e.c0) begin
					$error("col0: expected %0d, got %0d", e.c0, col0);
					errors++;
				end
				if (col1 !== e.c1) begin
					$error("col1: expected %0d, got %0d", e.c1, col1);
					errors++;
				end
				if (col2 !== e.c2) begin
					$error("col2: expected %0d, got %0d", e.c2, col2);
					errors++;
				end
				if (col3 !== e.c3) begin
					$error("col3: expected %0d, got %0d", e.c3, col3);
					errors++;
				end
				if (last_row !== e.last) begin
					$error("last_row: expected %0b, got %0b", e.last, last_row);
					errors++;
				end
			end
		end
	end

	initial begin
		pose_case_t pc;
		int         i;
		int         waited;
		errors         = 0;
		rows_checked   = 0;
		poses_sent     = 0;
		burst_left     = 0;
		arst_n         = 1'b0;
		start          = 1'b0;
		quat_x         = '0;
		quat_y         = '0;
		quat_z         = '0;
		quat_w         = '0;
		pos_x          = '0;
		pos_y          = '0;
		pos_z          = '0;
		scale_x        = '0;
		scale_y        = '0;
		scale_z        = '0;
		object_id      = '0;

		// identity rotation, unit scale, origin, lowest tag
		table_typed(mk_pose(0, 0, 0, 16384, 0, 0, 0, 256, 256, 256, 0),
			65536, 65536, 65536, 0, 0, 0);
		// unit scale passes position through, top tag
		table_typed(mk_pose(0, 0, 0, 16384, 65536, -65536, 32'h7fff_ffff,
			256, 256, 256, 16'hffff),
			65536, 65536, 65536, 65536, -65536, 32'h7fff_ffff);
		// largest position times largest scale clamps high
		table_typed(mk_pose(0, 0, 0, 16384, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32767, 32767, 32767, 16'h1234),
			8388352, 8388352, 8388352, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		// most negative times most negative clamps high
		table_typed(mk_pose(0, 0, 0, 16384, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			-32768, -32768, -32768, 16'h8000),
			-8388608, -8388608, -8388608, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
		// most negative position times largest scale clamps low
		table_typed(mk_pose(0, 0, 0, 16384, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32767, 32767, 32767, 16'h0001),
			8388352, 8388352, 8388352, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		// zero quaternion and zero scale give an all-zero upper part
		table_typed(mk_pose(0, 0, 0, 0, 32'h1234_5678, 32'h8765_4321, 32'h7fff_ffff,
			0, 0, 0, 16'h00ff),
			0, 0, 0, 0, 0, 0);
		// zero quaternion is not normalized: rotation part stays identity
		table_typed(mk_pose(0, 0, 0, 0, 32'h0001_2345, -7, 0, 256, 256, 256, 16'h0f0f),
			65536, 65536, 65536, 32'h0001_2345, -7, 0);
		// half turn about x
		table_typed(mk_pose(16384, 0, 0, 0, 1, 2, 3, 256, 256, 256, 16'h5555),
			65536, -65536, -65536, 1, 2, 3);
		// negative scale mirrors every axis
		table_typed(mk_pose(0, 0, 0, 16384, 65536, 1, 32'h8000_0000,
			-256, -256, -256, 16'haaaa),
			-65536, -65536, -65536, -65536, -1, 32'h7fff_ffff);
		// half scale: rounding of the translation goes half up
		table_typed(mk_pose(0, 0, 0, 16384, 1, -1, 3, 128, 128, 128, 16'h0002),
			32768, 32768, 32768, 1, 0, 2);
		// smallest scale step: rounding at the q8.8 lsb
		table_typed(mk_pose(0, 0, 0, 16384, 256, 127, 128, 1, 1, 1, 16'h0003),
			256, 256, 256, 1, 0, 1);
		// non-unit quaternions with every component at plus or minus one
		table_model(mk_pose(16384, 16384, 16384, 16384, 65536, 65536, 65536,
			256, 256, 256, 16'h0010));
		table_model(mk_pose(-16384, -16384, -16384, -16384, -65536, 0, 65536,
			32767, -32768, 256, 16'h0011));
		table_model(mk_pose(16384, -16384, 16384, -16384, 32'h7fff_ffff, 32'h8000_0000, 0,
			-32768, 32767, -256, 16'h0012));
		// quarter turn about z
		table_model(mk_pose(0, 0, 11585, 11585, 32'h0003_0000, 32'hffff_8000, 32'h0000_4000,
			256, 512, 384, 16'h0013));
		// quarter turn about y, uneven scale
		table_model(mk_pose(0, 11585, 0, 11585, 32'h0010_0000, 32'h0020_0000, -1,
			300, 200, 100, 16'h0014));
		// tiny components test the rotation rounding
		table_model(mk_pose(1, 0, 0, 0, 1, 1, 1, 1, 1, 1, 16'h0015));
		table_model(mk_pose(1, -1, 1, -1, 0, 0, 0, 32767, -32768, 32767, 16'h0016));
		table_model(mk_pose(-1, 3, -5, 7, -129, 129, -128, 3, -3, 5, 16'h0017));
		// unit-length general rotation with mixed-sign scale
		table_model(mk_pose(8192, -8192, 8192, 8192, 32'h0001_8000, 32'hfffe_8000, 32'h0000_0001,
			-200, 700, -1, 16'h0018));
		directed_count = pose_table.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table first
		for (i = 0; i < directed_count; i++) begin
			send_pose(pose_table[i].pose);
			queue_matrix_rows(pose_table[i]);
		end

		// then random poses; the block keeps no state from one pose to the next, so every pose is useful
		for (i = 0; i < 430; i++) begin
			pc.pose  = mk_pose(rand_quat(), rand_quat(), rand_quat(), rand_quat(),
				rand_pos(), rand_pos(), rand_pos(),
				rand_scale(), rand_scale(), rand_scale(), int'($urandom_range(0, 65535)));
			pc.typed = 1'b0;
			pc.dg    = '0;
			pc.tr    = '0;
			send_pose(pc.pose);
			queue_matrix_rows(pc);
		end
		start <= 1'b0;

		// let the pipeline drain, bounded
		waited = 0;
		while (rows_owed.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		if (rows_owed.size() != 0) begin
			$error("timeout: %0d row words never arrived", rows_owed.size());
			errors++;
		end
		// then keep watching to catch stray strobes
		repeat (16) @(posedge clk);

		$display("sent %0d poses (%0d from the table, rest random) in random bursts",
			poses_sent, directed_count);
		$display("checked %0d row words, %0d mismatches", rows_checked, errors);
		if (errors == 0)
			$display("quat_scale_translate_to_matrix regression: pass");
		else
			$display("quat_scale_translate_to_matrix regression: fail");
		$finish;
	end

endmodule
